### hw/rtl/channel_histogram_defines.svh
// Assertion macros for the channel histogram
`ifndef CHANNEL_HISTOGRAM_DEFINES_SVH
`define CHANNEL_HISTOGRAM_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger
`define CH_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define CH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/chist_pkg.sv
package chist_pkg;

  localparam int NumBins    = 256;
  localparam int BinIdxBits = $clog2(NumBins);
  localparam int CountBits  = 24;
  localparam int OutBits    = 24;
  localparam int WideBits   = (CountBits > OutBits) ? CountBits : OutBits;
  localparam int LumaBits   = 13;

  localparam logic [1:0] ChanRed   = 2'd0;
  localparam logic [1:0] ChanGreen = 2'd1;
  localparam logic [1:0] ChanBlue  = 2'd2;
  localparam logic [1:0] ChanGrey  = 2'd3;

  localparam logic [0:0] ActPixel = 1'b0;
  localparam logic [0:0] ActRead  = 1'b1;

  typedef struct packed {
    logic [0:0] action;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] bin_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         bin_number;
    logic [OutBits-1:0] bin_count;
  } out_item_t;

  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic rd_en;
    logic wb_en;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_read;
    logic out_free;
  } ctrl_sts_t;

endpackage

### hw/rtl/channel_histogram.sv
// 256-bin histogram of one colour channel of a pixel stream.
// Input requests (in_valid_i / in_stall_o) carry either a pixel to count or a
// bin to read and clear; read requests return the bin number and count on the
// output channel (out_valid_o / out_stall_i). Pixel requests return nothing.
// cfg_we_i / cfg_wdata_i set the channel: red, green, blue or grey, where grey is
// (11*r + 16*g + 5*b) >> 5. Write it only while the block is idle.
// Each request passes through capture, bin memory read and write back, in order.
// The bin memory read-modify-write lets no new request in until the last one
// has written back. A read result is loaded on the output in its write-back
// step. After reset the bin memory is swept to zero, one bin per cycle, over
// all 256 bins; in_stall_o stays high meanwhile. The channel resets to grey.
// A result waiting under out_stall_i does not block the next request; a further
// read request then waits in its write-back step until the output frees.
// Counts saturate at all ones.
module channel_histogram (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  chist_pkg::in_item_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output chist_pkg::out_item_t  out_data_o
);
  import chist_pkg::*;

  `include "channel_histogram_defines.svh"

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  chist_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  chist_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  `CH_ASSERT_NEXT(a_accept_stalls, in_valid_i && !in_stall_o, in_stall_o, "taken while busy")
  `CH_ASSERT_SAME(a_load_free, cmd.out_load, sts.out_free, "result loaded over a held result")
  `CH_ASSERT_SAME(a_one_write, cmd.clr_wr, !cmd.wb_en && !cmd.capture, "sweep overlaps a request")
  `CH_ASSERT_NEXT(a_read_then_wb, cmd.rd_en, !cmd.rd_en && in_stall_o, "no write back after read")

endmodule

### hw/rtl/chist_ctrl.sv
module chist_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  chist_pkg::ctrl_sts_t  sts_i,
  output chist_pkg::ctrl_cmd_t  cmd_o
);
  import chist_pkg::*;

  localparam logic [1:0] StClear  = 2'd0;
  localparam logic [1:0] StIdle   = 2'd1;
  localparam logic [1:0] StRead   = 2'd2;
  localparam logic [1:0] StModify = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StRead;
        end
      end
      StRead: begin
        cmd_o.rd_en = 1'b1;
        state_d     = StModify;
      end
      StModify: begin
        if (!sts_i.is_read) begin
          cmd_o.wb_en = 1'b1;
          state_d     = StIdle;
        end else if (sts_i.out_free) begin
          cmd_o.wb_en    = 1'b1;
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

### hw/rtl/chist_datapath.sv
module chist_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_wdata_i,
  input  chist_pkg::in_item_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output chist_pkg::out_item_t  out_data_o,
  input  chist_pkg::ctrl_cmd_t  cmd_i,
  output chist_pkg::ctrl_sts_t  sts_o
);
  import chist_pkg::*;

  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  logic [1:0]            chan_sel_q;
  logic [BinIdxBits-1:0] clr_cnt_q;
  logic [0:0]            action_q;
  logic [BinIdxBits-1:0] addr_q;
  logic [CountBits-1:0]  rdata_q;
  logic [CountBits-1:0]  bin_mem_q [NumBins];
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q;

  logic [LumaBits-1:0]   luma;
  logic [7:0]            pick;
  logic                  wr_en;
  logic [BinIdxBits-1:0] wr_addr;
  logic [CountBits-1:0]  wr_data;
  logic [CountBits-1:0]  count_inc;
  logic [WideBits-1:0]   count_wide;

  assign luma = LumaBits'(in_data_i.red) * LumaBits'(11)
              + (LumaBits'(in_data_i.green) << 4)
              + LumaBits'(in_data_i.blue) * LumaBits'(5);

  always_comb begin
    unique case (chan_sel_q)
      ChanRed:   pick = in_data_i.red;
      ChanGreen: pick = in_data_i.green;
      ChanBlue:  pick = in_data_i.blue;
      default:   pick = luma[LumaBits-1:LumaBits-8];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_sel_q <= ChanGrey;
      clr_cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        chan_sel_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= in_data_i.action;
      addr_q   <= (in_data_i.action == ActRead) ? BinIdxBits'(in_data_i.bin_index)
                                                : BinIdxBits'(pick);
    end
  end

  assign count_inc = (rdata_q == CountMax) ? rdata_q : rdata_q + 1'b1;
  assign wr_en     = cmd_i.clr_wr | cmd_i.wb_en;
  assign wr_addr   = cmd_i.clr_wr ? clr_cnt_q : addr_q;
  assign wr_data   = (cmd_i.clr_wr || action_q == ActRead) ? '0 : count_inc;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bin_mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= bin_mem_q[addr_q];
    end
  end

  assign count_wide = WideBits'(rdata_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.bin_number <= 8'(addr_q);
      out_q.bin_count  <= count_wide[OutBits-1:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign sts_o.clr_last  = (clr_cnt_q == BinIdxBits'(NumBins - 1));
  assign sts_o.is_read   = (action_q == ActRead);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import chist_pkg::*;

  class bin_ledger;
    logic [CountBits-1:0] bin_tally [NumBins];
    logic [1:0]           channel;
    out_item_t            pending_reads [$];
    int                   mismatches;

    function new();
      foreach (bin_tally[i]) bin_tally[i] = '0;
      channel    = ChanGrey;
      mismatches = 0;
    endfunction

    function logic [7:0] bin_of(in_item_t req);
      int luma;
      luma = (11 * int'(req.red) + 16 * int'(req.green) + 5 * int'(req.blue)) >> 5;
      case (channel)
        ChanRed:   return req.red;
        ChanGreen: return req.green;
        ChanBlue:  return req.blue;
        default:   return luma[7:0];
      endcase
    endfunction

    function void take_request(in_item_t req);
      logic [7:0] bin;
      out_item_t  res;
      if (req.action == ActPixel) begin
        bin = bin_of(req);
        if (bin_tally[bin] != '1) bin_tally[bin] = bin_tally[bin] + 1'b1;
      end else begin
        res.bin_number = req.bin_index;
        res.bin_count  = OutBits'(bin_tally[req.bin_index]);
        pending_reads  = {pending_reads, res};
        bin_tally[req.bin_index] = '0;
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_reads.size() == 0) begin
        report($sformatf("unexpected result bin %0d count %0d",
                         got.bin_number, got.bin_count));
        return;
      end
      want = pending_reads.pop_front();
      if (got.bin_number !== want.bin_number)
        report($sformatf("bin_number %0d, want %0d", got.bin_number, want.bin_number));
      if (got.bin_count !== want.bin_count)
        report($sformatf("bin %0d count %0d, want %0d",
                         want.bin_number, got.bin_count, want.bin_count));
    endtask
  endclass

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_wdata = ChanGrey;
  logic       in_valid  = 1'b0;
  in_item_t   in_data   = '0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  out_item_t  out_data;

  bin_ledger  ledger = new();
  logic [7:0] recent_bin = '0;
  logic       steady = 1'b0;
  int         stall_hold = 0;

  channel_histogram i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    int r;
    if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall  <= 1'b0;
        stall_hold = $urandom_range(0, 19);
      end else if (r < 85) begin
        out_stall  <= 1'b1;
        stall_hold = $urandom_range(0, 2);
      end else if (r < 95) begin
        out_stall  <= 1'b0;
        stall_hold = $urandom_range(30, 80);
      end else begin
        out_stall  <= 1'b1;
        stall_hold = $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) ledger.check_result(out_data);
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 70) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  task send(in_item_t req);
    int gap;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    ledger.take_request(req);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    in_item_t req;
    req.action    = ActPixel;
    req.red       = r;
    req.green     = g;
    req.blue      = b;
    req.bin_index = 8'($urandom);
    recent_bin    = ledger.bin_of(req);
    send(req);
  endtask

  task send_read(logic [7:0] bin);
    in_item_t req;
    req.action    = ActRead;
    req.red       = 8'($urandom);
    req.green     = 8'($urandom);
    req.blue      = 8'($urandom);
    req.bin_index = bin;
    send(req);
  endtask

  task hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (ledger.pending_reads.size() != 0);
  endtask

  task settle();
    hold_until_drained();
    repeat (8) @(posedge clk);
  endtask

  task set_channel(logic [1:0] ch);
    cfg_we    <= 1'b1;
    cfg_wdata <= ch;
    @(posedge clk);
    cfg_we         <= 1'b0;
    ledger.channel = ch;
  endtask

  task run_phase(int n, bit sweep);
    logic [7:0] base_r, base_g, base_b;
    int         pause_at;
    base_r   = 8'($urandom);
    base_g   = 8'($urandom);
    base_b   = 8'($urandom);
    pause_at = $urandom_range(n / 4, 3 * n / 4);
    for (int i = 0; i < n; i++) begin
      if (i % 48 == 0) steady = ($urandom_range(0, 3) == 0);
      if (i == pause_at) hold_until_drained();
      if ($urandom_range(0, 99) < 75) begin
        if ($urandom_range(0, 1))
          send_pixel(base_r + 8'($urandom_range(0, 7)), base_g + 8'($urandom_range(0, 7)),
                     base_b + 8'($urandom_range(0, 7)));
        else
          send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        send_read($urandom_range(0, 1) ? recent_bin : 8'($urandom));
      end
    end
    // read out the whole image
    if (sweep) for (int b = 0; b < NumBins; b++) send_read(8'(b));
    steady = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    set_channel(ChanGrey);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_read(8'd0);
    send_read(8'd255);
    send_read(8'd87);
    send_read(8'd127);
    send_read(8'd39);
    send_read(8'd0);
    settle();
    set_channel(ChanRed);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_read(8'd255);
    send_read(8'd0);
    settle();
    set_channel(ChanGreen);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_read(8'd255);
    settle();
    set_channel(ChanBlue);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_read(8'd255);
    send_read(8'd0);
    settle();
    for (int p = 0; p < 7; p++) begin
      set_channel(p < 4 ? 2'(p) : 2'($urandom_range(0, 3)));
      run_phase(155, p == 2 || p == 5);
      settle();
    end
    in_valid <= 1'b0;
    while (ledger.pending_reads.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending_reads.size() == 0)
      $display("[channel_histogram] OK");
    else
      $display("[channel_histogram] ERROR");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[channel_histogram] ERROR");
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/chist_pkg.sv
hw/rtl/chist_ctrl.sv
hw/rtl/chist_datapath.sv
hw/rtl/channel_histogram.sv
verif/testbench.sv
